// ----- sv/cltc_pkg.sv -----
`timescale 1ns / 1ps

package cltc_pkg;

    localparam int CNT_W   = 64;   // width of one tick counter
    localparam int LANES   = 4;    // user, low_user, system, idle
    localparam int SUM_W   = 66;   // busy and total sums, exact
    localparam int NUM_W   = 80;   // busy * LOAD_SCALE
    localparam int LOAD_W  = 14;
    localparam int STEP_W  = 7;    // serial bit counter
    localparam int DIVC_W  = 4;    // divider step counter
    localparam int IN_W    = 264;
    localparam int OUT_W   = 16;

    localparam logic [LOAD_W-1:0] LOAD_SCALE = 14'd10000;

    localparam logic [STEP_W-1:0] LAST_LANE_BIT = 7'(CNT_W - 1);
    localparam logic [STEP_W-1:0] LAST_SUM_BIT  = 7'(SUM_W - 1);
    localparam logic [STEP_W-1:0] LAST_NUM_BIT  = 7'(NUM_W - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SER    = 5'b00010,
        ST_LAUNCH = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_FIN    = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_WRAP = 2'd1,
        STAT_SEED = 2'd2,
        STAT_ZERO = 2'd3
    } status_t;

    typedef struct packed {
        logic              done;
        logic [LOAD_W-1:0] quot;
    } div_res_t;

endpackage

// ----- sv/cpu_load_from_tick_counters_top.sv -----
`timescale 1ns / 1ps
// CPU load from cumulative tick counters.
// Input stream s_axis: one beat carries cmd and the four cumulative counters
// (user, low-priority user, system, idle). cmd 0 seeds the stored counters,
// cmd 1 samples: load = floor(busy delta * 10000 / total delta).
// Output stream m_axis: one beat per input beat with load_hundredths and
// status (0 ok, 1 a counter went backwards, 2 seeded, 3 no elapsed ticks).
// Deltas, sums and busy*10000 are formed bit-serially, LSB first; a restoring
// divider then forms the quotient, one bit per step.
// s_axis_tready is high only while no item is in work, so a new item is
// accepted only after the last result has gone to the output register.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the next result waits in the final step
// until the output register frees up.
// Reset clears the stored counters to zero and empties the block.

module cpu_load_from_tick_counters_top
    import cltc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd, user_ticks, low_user_ticks, system_ticks, idle_ticks, zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // load_hundredths, status
    output logic [OUT_W-1:0] m_axis_tdata
);

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   cur_reg  [LANES];
    logic [CNT_W-1:0]   cur_next [LANES];
    logic [CNT_W-1:0]   prev_reg [LANES];
    logic [CNT_W-1:0]   prev_next[LANES];
    logic [LANES-1:0]   brw_reg, brw_next;
    logic [1:0]         bc_reg, bc_next;
    logic               tc_reg, tc_next;
    logic [LOAD_W-2:0]  hist_reg, hist_next;
    logic [3:0]         mc_reg, mc_next;
    logic               nz_reg, nz_next;
    logic [SUM_W-1:0]   tot_reg, tot_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    status_t            stat_reg, stat_next;
    logic               ov_reg, ov_next;
    logic [OUT_W-1:0]   od_reg, od_next;

    logic               accept;
    logic               lane_on;
    logic [LANES-1:0]   dbit;
    logic [2:0]         bsum;
    logic [1:0]         tsum;
    logic [4:0]         msum;
    logic               busy_bit;
    logic               div_start;
    div_res_t           div_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign lane_on       = (cnt_reg <= LAST_LANE_BIT);
    assign div_start     = (state_reg == ST_LAUNCH);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            dbit[i] = lane_on & (cur_reg[i][0] ^ prev_reg[i][0] ^ brw_reg[i]);
        end
        bsum     = 3'(dbit[0]) + 3'(dbit[1]) + 3'(dbit[2]) + 3'(bc_reg);
        busy_bit = bsum[0];
        tsum     = 2'(busy_bit) + 2'(dbit[3]) + 2'(tc_reg);
        msum     = 5'(LOAD_SCALE[0] & busy_bit) + 5'(mc_reg);
        for (int k = 1; k < LOAD_W; k++)
        begin
            msum = msum + 5'(LOAD_SCALE[k] & hist_reg[k-1]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        brw_next   = brw_reg;
        bc_next    = bc_reg;
        tc_next    = tc_reg;
        hist_next  = hist_reg;
        mc_next    = mc_reg;
        nz_next    = nz_reg;
        tot_next   = tot_reg;
        num_next   = num_reg;
        stat_next  = stat_reg;
        ov_next    = ov_reg && !m_axis_tready;
        od_next    = od_reg;
        for (int i = 0; i < LANES; i++)
        begin
            cur_next[i]  = cur_reg[i];
            prev_next[i] = prev_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = s_axis_tdata[0];
                    for (int i = 0; i < LANES; i++)
                    begin
                        cur_next[i] = s_axis_tdata[1 + i*CNT_W +: CNT_W];
                    end
                    cnt_next   = '0;
                    brw_next   = '0;
                    bc_next    = '0;
                    tc_next    = 1'b0;
                    hist_next  = '0;
                    mc_next    = '0;
                    nz_next    = 1'b0;
                    state_next = ST_SER;
                end
            end
            ST_SER:
            begin
                if (lane_on)
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        cur_next[i]  = {1'b0, cur_reg[i][CNT_W-1:1]};
                        prev_next[i] = {cur_reg[i][0], prev_reg[i][CNT_W-1:1]};
                        brw_next[i]  = (~cur_reg[i][0] & prev_reg[i][0]) |
                                       (~(cur_reg[i][0] ^ prev_reg[i][0]) & brw_reg[i]);
                    end
                end
                bc_next   = bsum[2:1];
                tc_next   = tsum[1];
                hist_next = {hist_reg[LOAD_W-3:0], busy_bit};
                mc_next   = msum[4:1];
                num_next  = {msum[0], num_reg[NUM_W-1:1]};
                if (cnt_reg <= LAST_SUM_BIT)
                begin
                    tot_next = {tsum[0], tot_reg[SUM_W-1:1]};
                    nz_next  = nz_reg | tsum[0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_NUM_BIT)
                begin
                    priority if (!cmd_reg)
                        stat_next = STAT_SEED;
                    else if (|brw_reg)
                        stat_next = STAT_WRAP;
                    else if (!nz_reg)
                        stat_next = STAT_ZERO;
                    else
                        stat_next = STAT_OK;
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = {stat_reg,
                                  (stat_reg == STAT_OK) ? div_res.quot : LOAD_W'(0)};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            for (int i = 0; i < LANES; i++)
            begin
                prev_reg[i] <= prev_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        cmd_reg  <= cmd_next;
        brw_reg  <= brw_next;
        bc_reg   <= bc_next;
        tc_reg   <= tc_next;
        hist_reg <= hist_next;
        mc_reg   <= mc_next;
        nz_reg   <= nz_next;
        tot_reg  <= tot_next;
        num_reg  <= num_next;
        stat_reg <= stat_next;
        od_reg   <= od_next;
        for (int i = 0; i < LANES; i++)
        begin
            cur_reg[i] <= cur_next[i];
        end
    end

    cltc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (num_reg),
        .denom (tot_reg),
        .res   (div_res)
    );

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

endmodule

// ----- sv/cltc_div.sv -----
`timescale 1ns / 1ps

module cltc_div
    import cltc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [SUM_W-1:0] denom,
    output div_res_t         res
);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DIVC_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [LOAD_W-1:0] q_reg, q_next;
    logic [SUM_W:0]    sh;
    logic [SUM_W+1:0]  diff;

    // quotient fits in LOAD_W bits, so the top of numer is already below denom
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sh        = {rem_reg, q_reg[LOAD_W-1]};
        diff      = {1'b0, sh} - {2'b00, denom};
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            rem_next  = numer[NUM_W-1:LOAD_W];
            q_next    = numer[LOAD_W-1:0];
        end
        else if (run_reg)
        begin
            if (!diff[SUM_W+1])
            begin
                rem_next = diff[SUM_W-1:0];
                q_next   = {q_reg[LOAD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = sh[SUM_W-1:0];
                q_next   = {q_reg[LOAD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == DIVC_W'(LOAD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign res.done = done_reg;
    assign res.quot = q_reg;

endmodule

// ----- sv/cltc_checker.sv -----
`timescale 1ns / 1ps

module cltc_checker
    import cltc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // load is zero unless status is ok
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[15:14] == STAT_OK) || (m_axis_tdata[13:0] == 14'd0))
        else $error("nonzero load with non-ok status");

    // load stays within 100.00 percent
    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[13:0] <= LOAD_SCALE)
        else $error("load above full scale");

endmodule

bind cpu_load_from_tick_counters_top cltc_checker u_cltc_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import cltc_pkg::*;

    localparam logic CMD_SEED   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;
    localparam logic [CNT_W-1:0] CMAX = '1;
    localparam int N_RANDOM   = 1130;
    localparam int SETTLE     = 120;
    localparam int CYCLE_CAP  = 1000000;
    localparam int MAX_WAIT   = 17;

    typedef struct packed {
        logic [LOAD_W-1:0] load;
        status_t           status;
    } load_beat_t;

    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] user;
        logic [CNT_W-1:0] low_user;
        logic [CNT_W-1:0] sys;
        logic [CNT_W-1:0] idle;
        logic             known;
        load_beat_t       res;
    } tick_row_t;

    localparam int N_ROWS = 20;

    // known rows carry a result read off by hand; others go through the predictor
    tick_row_t tick_rows [N_ROWS] = '{
        '{CMD_SAMPLE, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1, '{14'd0, STAT_ZERO}},
        '{CMD_SAMPLE, 64'd1, 64'd0, 64'd0, 64'd0, 1'b1, '{14'd10000, STAT_OK}},
        '{CMD_SAMPLE, 64'd1, 64'd0, 64'd0, 64'd1, 1'b1, '{14'd0, STAT_OK}},
        '{CMD_SEED, CMAX, CMAX, CMAX, CMAX, 1'b1, '{14'd0, STAT_SEED}},
        '{CMD_SAMPLE, CMAX, CMAX, CMAX, CMAX, 1'b1, '{14'd0, STAT_ZERO}},
        '{CMD_SAMPLE, CMAX - 64'd1, CMAX, CMAX, CMAX, 1'b1, '{14'd0, STAT_WRAP}},
        '{CMD_SAMPLE, CMAX, CMAX - 64'd1, CMAX, CMAX, 1'b1, '{14'd0, STAT_WRAP}},
        '{CMD_SAMPLE, CMAX, CMAX, 64'd0, CMAX, 1'b1, '{14'd0, STAT_WRAP}},
        '{CMD_SAMPLE, CMAX, CMAX, CMAX, 64'd0, 1'b1, '{14'd0, STAT_WRAP}},
        '{CMD_SEED, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1, '{14'd0, STAT_SEED}},
        '{CMD_SAMPLE, CMAX, CMAX, CMAX, CMAX, 1'b1, '{14'd7500, STAT_OK}},
        '{CMD_SEED, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1, '{14'd0, STAT_SEED}},
        '{CMD_SAMPLE, 64'd0, 64'd1, 64'd0, 64'd3, 1'b1, '{14'd2500, STAT_OK}},
        '{CMD_SAMPLE, 64'd0, 64'd1, 64'd1, 64'd5, 1'b1, '{14'd3333, STAT_OK}},
        '{CMD_SEED, {16{4'h5}}, {16{4'h5}}, {16{4'h5}}, {16{4'h5}},
          1'b1, '{14'd0, STAT_SEED}},
        '{CMD_SAMPLE, {16{4'hA}}, {16{4'hA}}, {16{4'hA}}, {16{4'hA}},
          1'b1, '{14'd7500, STAT_OK}},
        '{CMD_SEED, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1, '{14'd0, STAT_SEED}},
        '{CMD_SAMPLE, 64'd1, 64'd0, 64'd0, CMAX, 1'b0, '{14'd0, STAT_OK}},
        '{CMD_SAMPLE, CMAX, {16{4'h5}}, 64'd7, CMAX, 1'b0, '{14'd0, STAT_OK}},
        '{CMD_SAMPLE, CMAX, CMAX, 64'h0123_4567_89AB_CDEF, CMAX,
          1'b0, '{14'd0, STAT_OK}}
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    logic [CNT_W-1:0] last_user = '0;
    logic [CNT_W-1:0] last_low_user = '0;
    logic [CNT_W-1:0] last_sys = '0;
    logic [CNT_W-1:0] last_idle = '0;

    load_beat_t pending_loads [$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         beats_seen = 0;

    cpu_load_from_tick_counters_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("cpu_load_from_tick_counters_top: mismatch");
            $finish;
        end
    end

    function automatic load_beat_t predict_load(logic cmd, logic [CNT_W-1:0] u,
                                                logic [CNT_W-1:0] l,
                                                logic [CNT_W-1:0] s,
                                                logic [CNT_W-1:0] i);
        logic [127:0] busy;
        logic [127:0] total;
        load_beat_t   r;
        r.load = '0;
        if (cmd == CMD_SEED)
            r.status = STAT_SEED;
        else if (u < last_user || l < last_low_user || s < last_sys || i < last_idle)
            r.status = STAT_WRAP;
        else
        begin
            busy  = 128'(u - last_user) + 128'(l - last_low_user) + 128'(s - last_sys);
            total = busy + 128'(i - last_idle);
            if (total == '0)
                r.status = STAT_ZERO;
            else
            begin
                r.load   = LOAD_W'((busy * 128'(LOAD_SCALE)) / total);
                r.status = STAT_OK;
            end
        end
        last_user     = u;
        last_low_user = l;
        last_sys      = s;
        last_idle     = i;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] rand_ticks();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CNT_W-1:0] rand_delta();
        case ($urandom_range(0, 3))
            0: return CNT_W'($urandom_range(0, 1000));
            1: return CNT_W'($urandom);
            2: return rand_ticks() >> $urandom_range(0, 63);
            default: return '0;
        endcase
    endfunction

    function automatic int draw_wait(int idx);
        if ((idx / 50) % 4 == 3)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // mostly monotonic counter streams, with seeds, stalled clocks, wraps and noise
    task automatic make_sample(output tick_row_t row);
        int kind;
        int lane;
        logic [CNT_W-1:0] back;
        kind = $urandom_range(0, 99);
        row.known    = 1'b0;
        row.res      = '0;
        row.cmd      = CMD_SAMPLE;
        row.user     = last_user;
        row.low_user = last_low_user;
        row.sys      = last_sys;
        row.idle     = last_idle;
        if (kind < 70)
        begin
            row.user     = last_user + rand_delta();
            row.low_user = last_low_user + rand_delta();
            row.sys      = last_sys + rand_delta();
            row.idle     = last_idle + rand_delta();
        end
        else if (kind < 78)
        begin
            row.cmd      = CMD_SEED;
            row.user     = rand_ticks();
            row.low_user = rand_ticks();
            row.sys      = rand_ticks();
            row.idle     = rand_ticks();
        end
        else if (kind < 85)
        begin
        end
        else if (kind < 93)
        begin
            lane = $urandom_range(0, 3);
            back = CNT_W'($urandom_range(1, 1000));
            case (lane)
                0: row.user     = last_user - back;
                1: row.low_user = last_low_user - back;
                2: row.sys      = last_sys - back;
                default: row.idle = last_idle - back;
            endcase
        end
        else
        begin
            row.user     = rand_ticks();
            row.low_user = rand_ticks();
            row.sys      = rand_ticks();
            row.idle     = rand_ticks();
        end
    endtask

    task automatic send_row(tick_row_t row, int idx);
        int gap;
        load_beat_t r;
        gap = draw_wait(idx);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, row.idle, row.sys, row.low_user, row.user, row.cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = predict_load(row.cmd, row.user, row.low_user, row.sys, row.idle);
        if (row.known)
            r = row.res;
        pending_loads.push_back(r);
    endtask

    initial
    begin
        load_beat_t want;
        load_beat_t got;
        int stall;
        wait (rst_n);
        forever
        begin
            stall = draw_wait(beats_seen);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            beats_seen++;
            got.load   = m_axis_tdata[LOAD_W-1:0];
            got.status = status_t'(m_axis_tdata[OUT_W-1:LOAD_W]);
            if (pending_loads.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual load %0d status %0d",
                         $realtime, got.load, got.status);
                fail_count++;
            end
            else
            begin
                want = pending_loads.pop_front();
                if (got.load !== want.load)
                begin
                    $display("%0t: load_hundredths expected %0d actual %0d",
                             $realtime, want.load, got.load);
                    fail_count++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        tick_row_t row;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < N_ROWS; k++)
            send_row(tick_rows[k], k);
        for (int k = 0; k < N_RANDOM; k++)
        begin
            make_sample(row);
            send_row(row, k);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_loads.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("cpu_load_from_tick_counters_top: match");
        else
            $display("cpu_load_from_tick_counters_top: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
sv/cltc_pkg.sv
sv/cltc_div.sv
sv/cpu_load_from_tick_counters_top.sv
sv/cltc_checker.sv
tb/sv/tb_top.sv
